@@ rtl/core/bglt_pkg.sv @@
package bglt_pkg;

   // Field widths
   localparam int CELL_W   = 16;
   localparam int PACK_W   = 17;
   localparam int CAP_W    = 7;
   localparam int LEVEL_W  = 3;
   localparam int MODE_W   = 2;
   localparam int MARGIN_W = 4;
   localparam int CSR_IDX_W = 1;

   // Item queue between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // Charge mode codes
   localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CHARGING = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DONE     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NO_BATT  = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NO_BATT_THRESH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_MARGIN   = 1'b1;

   // Reset values
   localparam logic [PACK_W-1:0]   NO_BATT_THRESH_RST = 17'd8600;
   localparam logic [MARGIN_W-1:0] LEVEL_MARGIN_RST   = 4'd5;
   localparam logic [PACK_W-1:0]   LAST_PACK_RST      = 17'd8000;
   localparam logic [LEVEL_W-1:0]  LEVEL_RST          = 3'd5;

   // Capacity and level constants
   localparam int CAP_MAX    = 100;
   localparam int LEVEL_MAX  = 5;
   localparam int LEVEL_STEP = 20;
   localparam int FIVE_PCT_MV = 3476;

   localparam logic [CELL_W-1:0] VOLT_PTS [0:10] = '{
      16'd3449, 16'd3504, 16'd3545, 16'd3582, 16'd3620, 16'd3669,
      16'd3735, 16'd3821, 16'd3916, 16'd4023, 16'd4200
   };

   // One voltage threshold per percent step 1..100, nondecreasing
   typedef logic [CAP_MAX:1][CELL_W-1:0] thresh_type;

   function automatic thresh_type build_thresh();
      thresh_type t;
      int         d;
      int         j;
      int         lo;
      int         hi;
      t = '0;
      for (int k = 1; k <= CAP_MAX; k++) begin
         d  = k / 10;
         j  = k % 10;
         if (k == CAP_MAX) begin
            t[k] = VOLT_PTS[10];
         end else if (d == 0) begin
            // lowest decade splits at the extra five percent point
            if (j >= 5) begin
               lo = FIVE_PCT_MV;
               hi = int'(VOLT_PTS[1]);
               t[k] = CELL_W'(lo + (hi - lo) * (j - 5) / 5);
            end else begin
               lo = int'(VOLT_PTS[0]);
               hi = FIVE_PCT_MV;
               t[k] = CELL_W'(lo + (hi - lo) * j / 5);
            end
         end else begin
            lo = int'(VOLT_PTS[d]);
            hi = int'(VOLT_PTS[d + 1]);
            t[k] = CELL_W'(lo + (hi - lo) * j / 10);
         end
      end
      return t;
   endfunction

   localparam thresh_type CAP_THRESH = build_thresh();

   // Classified item held in the queue
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [PACK_W-1:0] pack_mv;
      logic [CAP_W-1:0]  cap;
   } item_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

endpackage

@@ rtl/core/battery_gauge_level_tracker_core.sv @@
// Battery gauge level tracker.
// Input channel req_*: one item per cell voltage sample with the charger
// pins; taken at a clock edge with req_valid high and req_stall low.
// Result channel rsp_*: one item per input item, in order, with charge
// mode, pack voltage, capacity in percent and the 0..5 gauge level.
// Register port csr_*: index 0 is the no-battery threshold, index 1 the
// level margin; csr_ready is always high, write only while idle.
// An item taken on the input is written into the queue by the front,
// then loaded into the output register by the back before it can leave.
// Throughput: one item per cycle; the front finishes classification in
// the accepting cycle, the back finishes the level in the popping cycle.
// When the receiver stalls, the result holds, the queue fills and then
// req_stall rises; nothing is dropped.
// Reset (synchronous): queue and output empty, threshold 8600, margin 5,
// stored pack voltage 8000, level 5.
module battery_gauge_level_tracker_core #(
   parameter int QUEUE_DEPTH = bglt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_charger_present,
   input  logic                           req_charge_done,
   input  logic [bglt_pkg::CELL_W-1:0]    req_cell_mv,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bglt_pkg::MODE_W-1:0]    rsp_charge_mode,
   output logic [bglt_pkg::PACK_W-1:0]    rsp_pack_mv,
   output logic [bglt_pkg::CAP_W-1:0]     rsp_capacity_pct,
   output logic [bglt_pkg::LEVEL_W-1:0]   rsp_gauge_level,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bglt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bglt_pkg::PACK_W-1:0]    csr_wdata
);
   import bglt_pkg::*;

   logic [PACK_W-1:0]   thresh_ff;
   logic [PACK_W-1:0]   thresh_in;
   logic [MARGIN_W-1:0] margin_ff;
   logic [MARGIN_W-1:0] margin_in;
   logic                csr_wr;
   logic                q_full;
   logic                push;
   item_type            push_item;
   logic                pop;
   q_head_type          head;

   // Configuration registers
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   always_comb begin
      thresh_in = thresh_ff;
      margin_in = margin_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_NO_BATT_THRESH: thresh_in = csr_wdata;
            CSR_LEVEL_MARGIN:   margin_in = csr_wdata[MARGIN_W-1:0];
            default:            thresh_in = thresh_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= NO_BATT_THRESH_RST;
         margin_ff <= LEVEL_MARGIN_RST;
      end else begin
         thresh_ff <= thresh_in;
         margin_ff <= margin_in;
      end
   end

   bglt_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_charger_present (req_charger_present),
      .req_charge_done     (req_charge_done),
      .req_cell_mv         (req_cell_mv),
      .no_batt_thresh      (thresh_ff),
      .q_full              (q_full),
      .push                (push),
      .push_item           (push_item)
   );

   bglt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .head      (head)
   );

   bglt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .level_margin     (margin_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_charge_mode  (rsp_charge_mode),
      .rsp_pack_mv      (rsp_pack_mv),
      .rsp_capacity_pct (rsp_capacity_pct),
      .rsp_gauge_level  (rsp_gauge_level)
   );

`ifndef ASSERT_OFF
   // Gauge level never leaves its range
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gauge_level <= LEVEL_W'(LEVEL_MAX)))
      else $error("gauge level out of range");

   // Empty capacity forces the empty level
   a_zero_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_capacity_pct == '0) |-> (rsp_gauge_level == '0))
      else $error("capacity zero without level zero");

   // A popped queue entry always reaches the output on the next edge
   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("popped item not presented");

   // Nothing is popped from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");
`endif

endmodule

@@ rtl/core/bglt_front.sv @@
module bglt_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_charger_present,
   input  logic                          req_charge_done,
   input  logic [bglt_pkg::CELL_W-1:0]   req_cell_mv,
   input  logic [bglt_pkg::PACK_W-1:0]   no_batt_thresh,
   input  logic                          q_full,
   output logic                          push,
   output bglt_pkg::item_type            push_item
);
   import bglt_pkg::*;

   logic [PACK_W-1:0] last_pack_ff;
   logic [PACK_W-1:0] last_pack_in;
   logic [PACK_W-1:0] pack_mv;
   logic [MODE_W-1:0] mode;
   logic [127:0]      ge;
   logic [CAP_W-1:0]  cap;
   logic [CAP_W-1:0]  cand;

   // Accept whenever the queue has room
   assign req_stall = q_full;
   assign push      = req_valid & ~q_full;

   assign pack_mv = {req_cell_mv, 1'b0};

   // Charge mode uses the pack voltage stored by the previous item
   always_comb begin
      if (!req_charger_present) begin
         mode = MODE_IDLE;
      end else if (last_pack_ff > no_batt_thresh) begin
         mode = MODE_NO_BATT;
      end else if (req_charge_done) begin
         mode = MODE_DONE;
      end else begin
         mode = MODE_CHARGING;
      end
   end

   // Comparator bank against every percent threshold
   always_comb begin
      ge    = '0;
      ge[0] = 1'b1;
      for (int k = 1; k <= CAP_MAX; k++) begin
         ge[k] = (req_cell_mv >= CAP_THRESH[k]);
      end
   end

   // Thermometer code to capacity by binary search on the top set bit
   always_comb begin
      cap  = '0;
      cand = '0;
      for (int b = CAP_W - 1; b >= 0; b--) begin
         cand = cap | (CAP_W'(1) << b);
         if (ge[cand]) begin
            cap = cand;
         end
      end
   end

   assign push_item.mode    = mode;
   assign push_item.pack_mv = pack_mv;
   assign push_item.cap     = cap;

   // Pack voltage memory
   assign last_pack_in = push ? pack_mv : last_pack_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pack_ff <= LAST_PACK_RST;
      end else begin
         last_pack_ff <= last_pack_in;
      end
   end

endmodule

@@ rtl/core/bglt_queue.sv @@
module bglt_queue #(
   parameter int DEPTH = bglt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bglt_pkg::item_type    push_item,
   output logic                  full,
   input  logic                  pop,
   output bglt_pkg::q_head_type  head
);
   import bglt_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/bglt_back.sv @@
module bglt_back (
   input  logic                          clock,
   input  logic                          reset,
   input  bglt_pkg::q_head_type          head,
   output logic                          pop,
   input  logic [bglt_pkg::MARGIN_W-1:0] level_margin,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bglt_pkg::MODE_W-1:0]   rsp_charge_mode,
   output logic [bglt_pkg::PACK_W-1:0]   rsp_pack_mv,
   output logic [bglt_pkg::CAP_W-1:0]    rsp_capacity_pct,
   output logic [bglt_pkg::LEVEL_W-1:0]  rsp_gauge_level
);
   import bglt_pkg::*;

   logic                 out_valid_ff;
   logic                 out_valid_in;
   item_type             out_item_ff;
   logic [LEVEL_W-1:0]   out_level_ff;
   logic [LEVEL_W-1:0]   level_ff;
   logic [LEVEL_W-1:0]   level_in;
   logic [LEVEL_W-1:0]   new_level;
   logic [7:0]           c8;
   logic [7:0]           m8;
   logic                 found;

   // Load the output register when it is empty or being taken
   assign pop = head.valid & (~out_valid_ff | ~rsp_stall);

   assign c8 = {1'b0, head.item.cap};
   assign m8 = {4'b0, level_margin};

   // Level hysteresis against the previous level
   always_comb begin
      new_level = level_ff;
      found     = 1'b0;
      if (head.item.cap == '0) begin
         new_level = '0;
      end else begin
         for (int i = LEVEL_MAX; i >= 1; i--) begin
            if (!found && (LEVEL_W'(i) > level_ff) &&
                (c8 > 8'(LEVEL_STEP * (i - 1)) + m8)) begin
               new_level = LEVEL_W'(i);
               found     = 1'b1;
            end
         end
         for (int i = 1; i <= LEVEL_MAX; i++) begin
            if (!found && (LEVEL_W'(i) < level_ff) &&
                (c8 + m8 < 8'(LEVEL_STEP * i))) begin
               new_level = LEVEL_W'(i);
               found     = 1'b1;
            end
         end
      end
   end

   assign level_in     = pop ? new_level : level_ff;
   assign out_valid_in = pop ? 1'b1 : (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= LEVEL_RST;
         out_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (pop) begin
         out_item_ff  <= head.item;
         out_level_ff <= new_level;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_charge_mode  = out_item_ff.mode;
   assign rsp_pack_mv      = out_item_ff.pack_mv;
   assign rsp_capacity_pct = out_item_ff.cap;
   assign rsp_gauge_level  = out_level_ff;

endmodule
